// ===== rtl/core/tetref_pkg.sv =====
// types, codes and lookup tables shared by the tetrahedron element operation unit
`default_nettype none

package tetref_pkg;

   // fixed field widths
   localparam int CW            = 23;
   localparam int LVL_W         = 5;
   localparam int TYPE_W        = 3;
   localparam int PICK_W        = 3;
   localparam int OP_W          = 3;
   localparam int FACE_W        = 2;
   localparam int MAX_LEVEL_DEF = 21;

   // operation codes carried on req_tuser
   typedef enum logic [OP_W-1:0] {
      OP_PARENT     = 3'd0,
      OP_CHILD      = 3'd1,
      OP_SIBLING    = 3'd2,
      OP_FACE_NBR   = 3'd3,
      OP_IS_PARENT  = 3'd4,
      OP_IS_SIBLING = 3'd5
   } op_type;

   typedef logic [TYPE_W-1:0] ttype_type;

   // request word, last declared field in the lowest bits
   typedef struct packed {
      logic [2:0]              pad;
      logic signed [CW-1:0]    other_z;
      logic signed [CW-1:0]    other_y;
      logic signed [CW-1:0]    other_x;
      logic [TYPE_W-1:0]       other_type;
      logic [LVL_W-1:0]        other_level;
      logic [PICK_W-1:0]       pick;
      logic signed [CW-1:0]    elem_z;
      logic signed [CW-1:0]    elem_y;
      logic signed [CW-1:0]    elem_x;
      logic [TYPE_W-1:0]       elem_type;
      logic [LVL_W-1:0]        elem_level;
   } req_data_type;

   // response word, last declared field in the lowest bits
   typedef struct packed {
      logic [6:0]              pad;
      logic                    bad_request;
      logic                    relation;
      logic [FACE_W-1:0]       back_face;
      logic signed [CW-1:0]    res_z;
      logic signed [CW-1:0]    res_y;
      logic signed [CW-1:0]    res_x;
      logic [TYPE_W-1:0]       res_type;
      logic [LVL_W-1:0]        res_level;
   } rsp_data_type;

   localparam int REQ_W = $bits(req_data_type);
   localparam int RSP_W = $bits(rsp_data_type);

   // parent type indexed by cube id and child type
   localparam ttype_type PARENT_TYPE [8][6] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
      '{3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0},
      '{3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3},
      '{3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1},
      '{3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd5},
      '{3'd0, 3'd0, 3'd0, 3'd5, 3'd5, 3'd5},
      '{3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5}
   };

   // child type indexed by parent type and bey child number
   localparam ttype_type CHILD_TYPE [6][8] = '{
      '{3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd2, 3'd1},
      '{3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd2, 3'd5, 3'd0},
      '{3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd1, 3'd4, 3'd3},
      '{3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd4, 3'd1, 3'd2},
      '{3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd0, 3'd5},
      '{3'd5, 3'd5, 3'd5, 3'd5, 3'd1, 3'd0, 3'd3, 3'd4}
   };

   // fold types 6 and 7 onto 0 and 1
   function automatic ttype_type norm_type(input ttype_type t);
      return (t >= 3'd6) ? ttype_type'(t - 3'd6) : t;
   endfunction

   // (t + k) mod 6 for t, k below 6
   function automatic ttype_type add_mod6(input ttype_type t, input ttype_type k);
      logic [TYPE_W:0] s;
      s = {1'b0, t} + {1'b0, k};
      return (s >= 4'd6) ? ttype_type'(s - 4'd6) : ttype_type'(s);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tet_refinement_ops.sv =====
// tetrahedron element operation unit: parent, child, sibling, face neighbor, relation tests
//
//   channel | dir | tdata                     | tuser
//   req_    | in  | element pair, pick (160b) | opcode (3b)
//   rsp_    | out | result element, flags (88b) | -
//
// One word per cycle sustained while rsp_tready stays high; a word passes
// through the input register and then the result register, with all table
// and add logic between the two. reset (synchronous) empties both registers.
// A stall on rsp_tready holds the result register; the input register keeps
// taking a word as long as the result register can move on.
`default_nettype none

module tet_refinement_ops import tetref_pkg::*; #(
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // elem_level, elem_type, elem_x, elem_y, elem_z, pick,
   // other_level, other_type, other_x, other_y, other_z, zero fill
   input  wire logic [REQ_W-1:0]   req_tdata,
   // opcode
   input  wire logic [OP_W-1:0]    req_tuser,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // res_level, res_type, res_x, res_y, res_z, back_face, relation,
   // bad_request, zero fill
   output logic [RSP_W-1:0]        rsp_tdata
);

   // coordinates carried wide enough to hold the root side length and a sign
   localparam int EW = (MAX_LEVEL + 2 > CW) ? MAX_LEVEL + 2 : CW;
   typedef logic [EW-1:0] ext_type;

   function automatic ext_type side_len(input logic [LVL_W-1:0] lvl);
      ext_type h;
      h = '0;
      if (int'(lvl) <= MAX_LEVEL) begin
         h = ext_type'(1) << (MAX_LEVEL - int'(lvl));
      end
      return h;
   endfunction

   function automatic logic [2:0] cube_id(input logic [LVL_W-1:0] lvl,
                                          input ext_type cx, input ext_type cy,
                                          input ext_type cz);
      ext_type h;
      h = side_len(lvl);
      if (lvl == '0) begin
         return 3'd0;
      end
      return {|(cz & h), |(cy & h), |(cx & h)};
   endfunction

   // input register
   logic         s1_valid_ff, s1_valid_in;
   req_data_type s1_data_ff;
   logic [OP_W-1:0] s1_op_ff;
   logic         req_fire, out_ok;

   // result register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   assign out_ok      = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || out_ok;
   assign req_fire    = req_tvalid && req_tready;
   assign s1_valid_in = req_fire || (s1_valid_ff && !out_ok);
   assign rsp_valid_in = out_ok ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data_type'(req_tdata);
         s1_op_ff   <= req_tuser;
      end
      if (out_ok && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // element operation
   always_comb begin
      logic [LVL_W-1:0] lv, olv, rl;
      ttype_type        ty, oty, rt;
      ext_type          c [3];
      ext_type          e [3];
      ext_type          o [3];
      ext_type          h, hc, half;
      logic [FACE_W-1:0] back, face;
      logic             rel, bad, do_child, even, up;
      logic [PICK_W-1:0] pick;
      logic [1:0]       ei, ej, fi;
      ttype_type        tsum;

      lv   = s1_data_ff.elem_level;
      olv  = s1_data_ff.other_level;
      ty   = norm_type(s1_data_ff.elem_type);
      oty  = norm_type(s1_data_ff.other_type);
      pick = s1_data_ff.pick;
      e[0] = ext_type'(s1_data_ff.elem_x);
      e[1] = ext_type'(s1_data_ff.elem_y);
      e[2] = ext_type'(s1_data_ff.elem_z);
      o[0] = ext_type'(s1_data_ff.other_x);
      o[1] = ext_type'(s1_data_ff.other_y);
      o[2] = ext_type'(s1_data_ff.other_z);
      c    = e;
      h    = side_len(lv);
      hc   = side_len(olv);
      half = '0;
      rl   = lv;
      rt   = ty;
      back = '0;
      face = pick[1:0];
      rel  = 1'b0;
      bad  = 1'b0;
      do_child = 1'b0;
      even = !ty[0];
      up   = 1'b0;
      ei   = ty[2:1];
      ej   = '0;
      fi   = '0;
      tsum = '0;

      case (s1_op_ff)
         OP_PARENT, OP_SIBLING: begin
            if (int'(lv) > MAX_LEVEL || lv == '0) begin
               bad = 1'b1;
            end else begin
               rt   = PARENT_TYPE[cube_id(lv, c[0], c[1], c[2])][ty];
               rl   = lv - 1'b1;
               c[0] = c[0] & ~h;
               c[1] = c[1] & ~h;
               c[2] = c[2] & ~h;
               // sibling: child of the parent
               if (s1_op_ff == OP_SIBLING) begin
                  lv = rl;
                  ty = rt;
                  h  = side_len(lv);
                  do_child = 1'b1;
               end
            end
         end
         OP_CHILD: begin
            if (int'(lv) >= MAX_LEVEL) begin
               bad = 1'b1;
            end else begin
               do_child = 1'b1;
            end
         end
         OP_FACE_NBR: begin
            if (int'(lv) > MAX_LEVEL) begin
               bad = 1'b1;
            end else if (face == 2'd1 || face == 2'd2) begin
               up   = (even == (face == 2'd2));
               rt   = up ? add_mod6(ty, 3'd1) : add_mod6(ty, 3'd5);
               back = face;
            end else if (face == 2'd0) begin
               c[ei] = c[ei] + h;
               rt    = add_mod6(ty, even ? 3'd4 : 3'd2);
               back  = 2'd3;
            end else begin
               tsum  = add_mod6(ty, 3'd3);
               fi    = tsum[2:1];
               c[fi] = c[fi] - h;
               rt    = add_mod6(ty, even ? 3'd2 : 3'd4);
               back  = 2'd0;
            end
         end
         OP_IS_PARENT: begin
            if (int'(lv) <= MAX_LEVEL && int'(olv) <= MAX_LEVEL) begin
               rel = ({1'b0, lv} + 1'b1 == {1'b0, olv}) &&
                     e[0] == (o[0] & ~hc) && e[1] == (o[1] & ~hc) &&
                     e[2] == (o[2] & ~hc) &&
                     ty == PARENT_TYPE[cube_id(olv, o[0], o[1], o[2])][oty];
            end
            rl = '0;
            rt = '0;
            c[0] = '0;
            c[1] = '0;
            c[2] = '0;
         end
         OP_IS_SIBLING: begin
            if (int'(lv) <= MAX_LEVEL && int'(olv) <= MAX_LEVEL && lv != '0) begin
               rel = (lv == olv) &&
                     ((e[0] ^ o[0]) & ~h) == '0 && ((e[1] ^ o[1]) & ~h) == '0 &&
                     ((e[2] ^ o[2]) & ~h) == '0 &&
                     PARENT_TYPE[cube_id(lv, e[0], e[1], e[2])][ty] ==
                        PARENT_TYPE[cube_id(olv, o[0], o[1], o[2])][oty] &&
                     ty != oty;
            end
            rl = '0;
            rt = '0;
            c[0] = '0;
            c[1] = '0;
            c[2] = '0;
         end
         default: begin
            rl = '0;
            rt = '0;
            c[0] = '0;
            c[1] = '0;
            c[2] = '0;
            bad = 1'b1;
         end
      endcase

      // bey child: shift the anchor by half a side along the chosen axes
      if (do_child) begin
         ei   = ty[2:1];
         if (!ty[0]) begin
            ej = (ei == 2'd0) ? 2'd2 : 2'(ei - 2'd1);
         end else begin
            ej = (ei == 2'd2) ? 2'd0 : 2'(ei + 2'd1);
         end
         half = h >> 1;
         if (pick inside {3'd1, 3'd4, 3'd5}) begin
            c[ei] = c[ei] + half;
         end else if (pick inside {3'd2, 3'd6, 3'd7}) begin
            c[ei] = c[ei] + half;
            c[ej] = c[ej] + half;
         end else if (pick == 3'd3) begin
            c[0] = c[0] + half;
            c[1] = c[1] + half;
            c[2] = c[2] + half;
         end
         rt = CHILD_TYPE[ty][pick];
         rl = lv + 1'b1;
      end

      rsp_data_in             = '0;
      rsp_data_in.res_level   = rl;
      rsp_data_in.res_type    = rt;
      rsp_data_in.res_x       = c[0][CW-1:0];
      rsp_data_in.res_y       = c[1][CW-1:0];
      rsp_data_in.res_z       = c[2][CW-1:0];
      rsp_data_in.back_face   = back;
      rsp_data_in.relation    = rel;
      rsp_data_in.bad_request = bad;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // a result appears only after a word sat in the input register
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result word without a staged request");

   // a blocked input register keeps its word
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_ok |=> s1_valid_ff && $stable(s1_data_ff) && $stable(s1_op_ff))
      else $error("staged request lost while result register blocked");

   // an accepted word is staged in the next cycle
   a_accept_staged: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted request not staged");

   // relation answers are never flagged as bad requests
   a_rel_not_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.relation && rsp_data_ff.bad_request))
      else $error("relation set on a bad request");

endmodule

`default_nettype wire

// ===== verif/tb_tet_refinement_ops.sv =====
// testbench for the tetrahedron element operation unit: directed probes, then random streams
module tb_tet_refinement_ops;
   timeunit 1ns;
   timeprecision 1ps;

   import tetref_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1350;
   localparam int LONG_HOLD    = 60;
   localparam int TAIL_CYCLES  = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAXL         = MAX_LEVEL_DEF;

   // opcodes outside the operation set
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct {
      logic [OP_W-1:0] op;
      req_data_type    q;
      bit              fixed;
      rsp_data_type    want;
   } probe_row;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata;
   logic [OP_W-1:0]      req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_W-1:0]     rsp_tdata;

   // answer typed into the probe list for the word on the bus
   bit                   fixed_now;
   rsp_data_type         fixed_rsp;

   rsp_data_type         awaited_answers [$];
   probe_row             probe_rows [$];
   int                   mismatch_count = 0;
   int                   cycle_count = 0;
   int                   hold_requests = 0;

   tet_refinement_ops #(.MAX_LEVEL(MAXL)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- element math

   function automatic logic [CW-1:0] side_of(input int level);
      if (level > MAXL) return '0;
      return CW'(1) << (MAXL - level);
   endfunction

   function automatic int fold_type(input int t);
      return (t >= 6) ? t - 6 : t;
   endfunction

   function automatic int cube_of(input int level, input logic [CW-1:0] ax,
                                  input logic [CW-1:0] ay, input logic [CW-1:0] az);
      logic [CW-1:0] h;
      if (level == 0) return 0;
      h = side_of(level);
      return int'((ax & h) != 0) + 2 * int'((ay & h) != 0) + 4 * int'((az & h) != 0);
   endfunction

   // parent type by cube id, listed for child types 0..5
   function automatic int parent_type_for(input int cube, input int ty);
      logic [17:0] row;
      case (cube)
         0:       row = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
         1:       row = {3'd0, 3'd1, 3'd1, 3'd1, 3'd0, 3'd0};
         2:       row = {3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3};
         3:       row = {3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd1};
         4:       row = {3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd5};
         5:       row = {3'd0, 3'd0, 3'd0, 3'd5, 3'd5, 3'd5};
         6:       row = {3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4};
         default: row = {3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5};
      endcase
      return int'(row[(5 - ty) * 3 +: 3]);
   endfunction

   // child type by parent type, listed for bey numbers 0..7
   function automatic int child_type_for(input int ty, input int pk);
      logic [23:0] row;
      case (ty)
         0:       row = {3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd5, 3'd2, 3'd1};
         1:       row = {3'd1, 3'd1, 3'd1, 3'd1, 3'd3, 3'd2, 3'd5, 3'd0};
         2:       row = {3'd2, 3'd2, 3'd2, 3'd2, 3'd0, 3'd1, 3'd4, 3'd3};
         3:       row = {3'd3, 3'd3, 3'd3, 3'd3, 3'd5, 3'd4, 3'd1, 3'd2};
         4:       row = {3'd4, 3'd4, 3'd4, 3'd4, 3'd2, 3'd3, 3'd0, 3'd5};
         default: row = {3'd5, 3'd5, 3'd5, 3'd5, 3'd1, 3'd0, 3'd3, 3'd4};
      endcase
      return int'(row[(7 - pk) * 3 +: 3]);
   endfunction

   // answer word for one request
   function automatic rsp_data_type tet_op_answer(input logic [OP_W-1:0] op,
                                                  input req_data_type q);
      rsp_data_type    r;
      logic [OP_W-1:0] kind;
      logic [CW-1:0]   c [0:2];
      logic [CW-1:0]   o [0:2];
      logic [CW-1:0]   h, hc;
      int              lv, olv, ty, oty, rl, rt, back, rel, bad, pk, face, ei, ej, i;
      bit              even, up;
      kind = op;
      lv   = int'(q.elem_level);
      olv  = int'(q.other_level);
      ty   = fold_type(int'(q.elem_type));
      oty  = fold_type(int'(q.other_type));
      c[0] = q.elem_x;
      c[1] = q.elem_y;
      c[2] = q.elem_z;
      o[0] = q.other_x;
      o[1] = q.other_y;
      o[2] = q.other_z;
      pk   = int'(q.pick);
      h    = side_of(lv);
      rl   = lv;
      rt   = ty;
      back = 0;
      rel  = 0;
      bad  = 0;

      // parent step, also the first half of a sibling
      if (kind <= OP_FACE_NBR && lv > MAXL) begin
         bad = 1;
      end else if (kind == OP_PARENT || kind == OP_SIBLING) begin
         if (lv == 0) begin
            bad = 1;
         end else begin
            rt = parent_type_for(cube_of(lv, c[0], c[1], c[2]), ty);
            rl = lv - 1;
            for (i = 0; i < 3; i++) c[i] = c[i] & ~h;
            if (kind == OP_SIBLING) begin
               lv   = rl;
               ty   = rt;
               h    = side_of(lv);
               kind = OP_CHILD;
            end
         end
      end else if (kind == OP_CHILD && lv >= MAXL) begin
         bad = 1;
      end

      if (kind == OP_CHILD && bad == 0) begin
         // bey child: shift the anchor by half a side along the type's axes
         ei = ty / 2;
         ej = (ty % 2 == 0) ? (ei + 2) % 3 : (ei + 1) % 3;
         case (pk)
            1, 4, 5: c[ei] = c[ei] + (h >> 1);
            2, 6, 7: begin
               c[ei] = c[ei] + (h >> 1);
               c[ej] = c[ej] + (h >> 1);
            end
            3: for (i = 0; i < 3; i++) c[i] = c[i] + (h >> 1);
            default: ;
         endcase
         rt = child_type_for(ty, pk);
         rl = lv + 1;
      end else if (kind == OP_FACE_NBR && bad == 0) begin
         face = pk & 3;
         even = (ty % 2 == 0);
         if (face == 1 || face == 2) begin
            up   = (even == (face == 2));
            rt   = up ? (ty + 1) % 6 : (ty + 5) % 6;
            back = face;
         end else if (face == 0) begin
            c[ty / 2] = c[ty / 2] + h;
            rt   = (ty + (even ? 4 : 2)) % 6;
            back = 3;
         end else begin
            c[((ty + 3) % 6) / 2] = c[((ty + 3) % 6) / 2] - h;
            rt   = (ty + (even ? 2 : 4)) % 6;
            back = 0;
         end
      end else if (kind == OP_IS_PARENT || kind == OP_IS_SIBLING) begin
         rl = 0;
         rt = 0;
         for (i = 0; i < 3; i++) c[i] = '0;
         if (lv <= MAXL && olv <= MAXL) begin
            if (kind == OP_IS_PARENT) begin
               hc  = side_of(olv);
               rel = (lv + 1 == olv) && q.elem_x == (o[0] & ~hc) &&
                     q.elem_y == (o[1] & ~hc) && q.elem_z == (o[2] & ~hc) &&
                     ty == parent_type_for(cube_of(olv, o[0], o[1], o[2]), oty);
            end else if (lv != 0) begin
               rel = (lv == olv) && ((q.elem_x ^ o[0]) & ~h) == 0 &&
                     ((q.elem_y ^ o[1]) & ~h) == 0 && ((q.elem_z ^ o[2]) & ~h) == 0 &&
                     parent_type_for(cube_of(lv, q.elem_x, q.elem_y, q.elem_z), ty) ==
                     parent_type_for(cube_of(olv, o[0], o[1], o[2]), oty) &&
                     ty != oty;
            end
         end
      end else if (kind > OP_IS_SIBLING) begin
         rl  = 0;
         rt  = 0;
         for (i = 0; i < 3; i++) c[i] = '0;
         bad = 1;
      end

      r             = '0;
      r.res_level   = LVL_W'(rl);
      r.res_type    = TYPE_W'(rt);
      r.res_x       = c[0];
      r.res_y       = c[1];
      r.res_z       = c[2];
      r.back_face   = FACE_W'(back);
      r.relation    = 1'(rel);
      r.bad_request = 1'(bad);
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic req_data_type make_req(input int lv, input int ty, input int x,
                                             input int y, input int z, input int pk,
                                             input int olv, input int oty, input int ox,
                                             input int oy, input int oz);
      req_data_type q;
      q             = '0;
      q.elem_level  = LVL_W'(lv);
      q.elem_type   = TYPE_W'(ty);
      q.elem_x      = CW'(x);
      q.elem_y      = CW'(y);
      q.elem_z      = CW'(z);
      q.pick        = PICK_W'(pk);
      q.other_level = LVL_W'(olv);
      q.other_type  = TYPE_W'(oty);
      q.other_x     = CW'(ox);
      q.other_y     = CW'(oy);
      q.other_z     = CW'(oz);
      return q;
   endfunction

   function automatic rsp_data_type make_rsp(input int lv, input int ty, input int x,
                                             input int y, input int z, input int back,
                                             input int rel, input int bad);
      rsp_data_type r;
      r             = '0;
      r.res_level   = LVL_W'(lv);
      r.res_type    = TYPE_W'(ty);
      r.res_x       = CW'(x);
      r.res_y       = CW'(y);
      r.res_z       = CW'(z);
      r.back_face   = FACE_W'(back);
      r.relation    = 1'(rel);
      r.bad_request = 1'(bad);
      return r;
   endfunction

   // second element taken from a computed relative
   function automatic req_data_type with_other(input req_data_type q, input rsp_data_type r);
      q.other_level = r.res_level;
      q.other_type  = r.res_type;
      q.other_x     = r.res_x;
      q.other_y     = r.res_y;
      q.other_z     = r.res_z;
      return q;
   endfunction

   function automatic int random_level();
      if ($urandom_range(0, 9) == 0) return $urandom_range(MAXL + 1, (1 << LVL_W) - 1);
      return $urandom_range(0, MAXL);
   endfunction

   function automatic int random_type();
      if ($urandom_range(0, 9) == 0) return $urandom_range(6, 7);
      return $urandom_range(0, 5);
   endfunction

   // mostly anchors aligned inside the root cube, some raw 23-bit values
   function automatic logic [CW-1:0] rand_anchor(input int level);
      logic [CW-1:0] v;
      logic [CW-1:0] h;
      v = CW'($urandom);
      if ($urandom_range(0, 3) == 0) return v;
      h = side_of(level);
      v = v & (side_of(0) - CW'(1));
      if (h != 0) v = v & ~(h - CW'(1));
      return v;
   endfunction

   task automatic rand_request(output logic [OP_W-1:0] op, output req_data_type q);
      rsp_data_type kin;
      int           k;
      if ($urandom_range(0, 99) < 4) op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
      else op = OP_W'($urandom_range(OP_PARENT, OP_IS_SIBLING));
      q             = '0;
      q.elem_level  = LVL_W'(random_level());
      q.elem_type   = TYPE_W'(random_type());
      q.elem_x      = rand_anchor(int'(q.elem_level));
      q.elem_y      = rand_anchor(int'(q.elem_level));
      q.elem_z      = rand_anchor(int'(q.elem_level));
      q.pick        = PICK_W'($urandom_range(0, 7));
      q.other_level = LVL_W'(random_level());
      q.other_type  = TYPE_W'(random_type());
      q.other_x     = rand_anchor(int'(q.other_level));
      q.other_y     = rand_anchor(int'(q.other_level));
      q.other_z     = rand_anchor(int'(q.other_level));
      // comparisons mostly against a true child or sibling, some spoiled
      if ((op == OP_IS_PARENT || op == OP_IS_SIBLING) && $urandom_range(0, 9) < 7) begin
         kin = tet_op_answer((op == OP_IS_PARENT) ? OP_CHILD : OP_SIBLING, q);
         q   = with_other(q, kin);
         if ($urandom_range(0, 4) == 0) begin
            k = $urandom_range(0, CW - 1);
            q.other_x[k] = ~q.other_x[k];
         end
         if ($urandom_range(0, 9) == 0) q.other_type = TYPE_W'(random_type());
      end
   endtask

   // ---------------------------------------------------------------- request side

   task automatic send_word(input logic [OP_W-1:0] op, input req_data_type q,
                            input bit fixed, input rsp_data_type want);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= q;
      fixed_now  <= fixed;
      fixed_rsp  <= want;
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      @(negedge clock);
   endtask

   task automatic idle_sender(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom});
         req_tuser  <= OP_W'($urandom);
         repeat (n) @(negedge clock);
      end
   endtask

   // stop offering and let every awaited answer come back
   task automatic drain_answers();
      if (req_tvalid) req_tvalid <= 1'b0;
      forever begin
         @(negedge clock);
         if (awaited_answers.size() == 0) break;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_field(input string field, input logic signed [63:0] want,
                               input logic signed [63:0] got);
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
   endtask

   task automatic check_answer(input rsp_data_type want, input rsp_data_type got);
      if (got.res_level !== want.res_level)
         report_field("res_level", want.res_level, got.res_level);
      if (got.res_type !== want.res_type)
         report_field("res_type", want.res_type, got.res_type);
      if (got.res_x !== want.res_x) report_field("res_x", want.res_x, got.res_x);
      if (got.res_y !== want.res_y) report_field("res_y", want.res_y, got.res_y);
      if (got.res_z !== want.res_z) report_field("res_z", want.res_z, got.res_z);
      if (got.back_face !== want.back_face)
         report_field("back_face", want.back_face, got.back_face);
      if (got.relation !== want.relation)
         report_field("relation", want.relation, got.relation);
      if (got.bad_request !== want.bad_request)
         report_field("bad_request", want.bad_request, got.bad_request);
      if (got.pad !== want.pad) report_field("zero fill", want.pad, got.pad);
   endtask

   // result words against the oldest awaited answer, request words into the queue
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_answers.size() == 0) begin
               mismatch_count++;
               $display("%0t: no word expected, got %h", $time, rsp_tdata);
            end else begin
               check_answer(awaited_answers.pop_front(), rsp_tdata);
            end
         end
         if (req_tvalid && req_tready)
            awaited_answers.push_back(fixed_now ? fixed_rsp : tet_op_answer(req_tuser, req_tdata));
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- result side

   // stall pattern changes mode at the end of each random-length run; long hold on request
   initial begin
      int mode;
      int run_left;
      int holds_done;
      rsp_tready = 1'b0;
      mode       = 0;
      run_left   = 0;
      holds_done = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (run_left == 0) begin
            mode     = $urandom_range(0, 3);
            run_left = $urandom_range(16, 96);
         end
         run_left--;
         case (mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= (run_left % 3 == 0);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      req_data_type     q;
      rsp_data_type     none;
      logic [OP_W-1:0]  op;
      probe_row         row;
      int               k, sent, burst_no, len;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      fixed_now  = 1'b0;
      fixed_rsp  = '0;
      none       = '0;

      // probes with answers read off directly
      // parent at level zero
      probe_rows.push_back('{OP_PARENT, make_req(0, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             make_rsp(0, 3, 0, 0, 0, 0, 0, 1)});
      // sibling at level zero, type 7 folds onto 1
      probe_rows.push_back('{OP_SIBLING, make_req(0, 7, 100, 200, 300, 2, 0, 0, 0, 0, 0),
                             1'b1, make_rsp(0, 1, 100, 200, 300, 0, 0, 1)});
      // child at the maximum level, extreme anchors
      probe_rows.push_back('{OP_CHILD,
                             make_req(MAXL, 5, 4194303, -4194304, 1, 7, 0, 0, 0, 0, 0),
                             1'b1, make_rsp(MAXL, 5, 4194303, -4194304, 1, 0, 0, 1)});
      // child beyond the maximum level
      probe_rows.push_back('{OP_CHILD, make_req(31, 2, 8, 16, 24, 3, 0, 0, 0, 0, 0), 1'b1,
                             make_rsp(31, 2, 8, 16, 24, 0, 0, 1)});
      // face neighbor beyond the maximum level, type 6 folds onto 0
      probe_rows.push_back('{OP_FACE_NBR, make_req(22, 6, 5, 6, 7, 1, 0, 0, 0, 0, 0), 1'b1,
                             make_rsp(22, 0, 5, 6, 7, 0, 0, 1)});
      // unknown opcodes
      probe_rows.push_back('{OP_SPARE_LO, make_req(10, 4, -1, -1, -1, 7, MAXL, 5, -1, -1, -1),
                             1'b1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1)});
      probe_rows.push_back('{OP_SPARE_HI,
                             make_req(31, 7, 4194303, 4194303, 4194303, 7,
                                      31, 7, 4194303, 4194303, 4194303),
                             1'b1, make_rsp(0, 0, 0, 0, 0, 0, 0, 1)});
      // first child of the root
      probe_rows.push_back('{OP_CHILD, make_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             make_rsp(1, 0, 0, 0, 0, 0, 0, 0)});
      // comparisons with a level out of range, and a sibling test at level zero
      probe_rows.push_back('{OP_IS_PARENT, make_req(30, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1'b1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 0)});
      probe_rows.push_back('{OP_IS_SIBLING, make_req(0, 2, 0, 0, 0, 0, 0, 2, 0, 0, 0), 1'b1,
                             make_rsp(0, 0, 0, 0, 0, 0, 0, 0)});

      // probes checked by the predictor
      // every bey child number, types cycling through the folded ones
      for (k = 0; k < 8; k++)
         probe_rows.push_back('{OP_CHILD, make_req(20, k, 2 * k, 4 * k, 6 * k, k,
                                                   0, 0, 0, 0, 0), 1'b0, none});
      probe_rows.push_back('{OP_PARENT, make_req(MAXL, 4, 2097151, 1, 4194303, 0,
                                                 0, 0, 0, 0, 0), 1'b0, none});
      probe_rows.push_back('{OP_SIBLING, make_req(1, 2, 1 << 20, 0, 1 << 20, 6,
                                                  0, 0, 0, 0, 0), 1'b0, none});
      // faces 0..3, high pick bits ignored, anchors wrapping both ways
      probe_rows.push_back('{OP_FACE_NBR, make_req(0, 0, 4194303, 0, 0, 4, 0, 0, 0, 0, 0),
                             1'b0, none});
      probe_rows.push_back('{OP_FACE_NBR, make_req(5, 1, 1 << 16, 1 << 17, 0, 5,
                                                   0, 0, 0, 0, 0), 1'b0, none});
      probe_rows.push_back('{OP_FACE_NBR, make_req(12, 2, 512, 1024, 4096, 2,
                                                   0, 0, 0, 0, 0), 1'b0, none});
      probe_rows.push_back('{OP_FACE_NBR, make_req(0, 3, -4194304, 0, 0, 3, 0, 0, 0, 0, 0),
                             1'b0, none});
      // true relations built from a computed child and sibling
      q = make_req(3, 1, 3 << 18, 1 << 18, 5 << 18, 5, 0, 0, 0, 0, 0);
      probe_rows.push_back('{OP_IS_PARENT, with_other(q, tet_op_answer(OP_CHILD, q)),
                             1'b0, none});
      q.pick = 3'd4;
      probe_rows.push_back('{OP_IS_SIBLING, with_other(q, tet_op_answer(OP_SIBLING, q)),
                             1'b0, none});

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part
      foreach (probe_rows[i]) begin
         row = probe_rows[i];
         send_word(row.op, row.q, row.fixed, row.want);
         idle_sender($urandom_range(0, 2));
      end
      drain_answers();

      // random part in bursts
      sent     = 0;
      burst_no = 0;
      while (sent < RANDOM_ITEMS) begin
         burst_no++;
         if (burst_no % 20 == 15) drain_answers();
         if (burst_no % 20 == 7) begin
            // receiver holds off while a long burst piles up
            hold_requests++;
            len = 24;
         end else begin
            len = $urandom_range(1, 12);
         end
         for (k = 0; k < len; k++) begin
            rand_request(op, q);
            send_word(op, q, 1'b0, none);
            sent++;
         end
         if (burst_no % 20 != 6 && $urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 8));
      end

      drain_answers();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/tetref_pkg.sv
rtl/core/tet_refinement_ops.sv
verif/tb_tet_refinement_ops.sv
